// ===== sv/gpt_pkg.sv =====
package gpt_pkg;

   localparam int PART_W = 7;
   localparam int NORM_W = 14;
   localparam int SQ_W = 2 * PART_W;
   localparam int SUM_W = SQ_W + 1;
   localparam logic [PART_W-1:0] MAX_COORD_RESET = 7'd50;
   localparam logic [NORM_W-1:0] NORM_MAX = 14'h3fff;
   localparam logic [1:0] AXIS_RESIDUE = 2'd3;

   typedef struct packed {
      logic [PART_W-1:0] real_part;
      logic [PART_W-1:0] imag_part;
   } req_payload_type;

   typedef struct packed {
      logic              is_gaussian_prime;
      logic [NORM_W-1:0] norm_value;
      logic              in_range;
   } rsp_payload_type;

   // first stage result: squares and classification of the query
   typedef struct packed {
      logic              ok;
      logic              both_nz;
      logic              axis_cand;
      logic [PART_W-1:0] axis_val;
      logic [SQ_W-1:0]   a_sq;
      logic [SQ_W-1:0]   b_sq;
   } stage_a_type;

endpackage

// ===== sv/gpt_sieve_map.sv =====
module gpt_sieve_map
   import gpt_pkg::*;
#(
   parameter int MAX_COORD_LIMIT = 64
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   rd_en,
   input  logic [$clog2(2*MAX_COORD_LIMIT*MAX_COORD_LIMIT+1)-1:0] rd_addr,
   output logic                                                   rd_bit,
   output logic                                                   map_ready
);

   localparam int TOP = 2 * MAX_COORD_LIMIT * MAX_COORD_LIMIT;
   localparam int DEPTH = TOP + 1;
   localparam int AW = $clog2(DEPTH);
   localparam int JW = AW + 1;
   localparam int IW = $clog2(MAX_COORD_LIMIT) + 2;

   typedef enum logic [2:0] {
      SV_FILL = 3'b001,
      SV_MARK = 3'b010,
      SV_DONE = 3'b100
   } sieve_state_type;

   sieve_state_type state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [IW-1:0] i_ff, i_in;
   logic [JW-1:0] sq_ff, sq_in;
   logic [JW-1:0] j_ff, j_in;
   logic [JW-1:0] nsq;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          wr_bit;
   logic          prime_map_ff [DEPTH];
   logic          rd_bit_ff;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      i_in     = i_ff;
      sq_in    = sq_ff;
      j_in     = j_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_bit   = 1'b0;
      nsq      = sq_ff + JW'({i_ff, 1'b1});
      unique case (state_ff)
         SV_FILL: begin
            wr_en  = 1'b1;
            wr_bit = (addr_ff >= AW'(2));
            if (addr_ff == AW'(TOP)) begin
               state_in = SV_MARK;
               i_in     = IW'(2);
               sq_in    = JW'(4);
               j_in     = JW'(4);
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         SV_MARK: begin
            // strike multiples of every i with i*i inside the map
            if (j_ff <= JW'(TOP)) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[AW-1:0];
               j_in    = j_ff + JW'(i_ff);
            end else if (nsq > JW'(TOP)) begin
               state_in = SV_DONE;
            end else begin
               i_in  = i_ff + 1'b1;
               sq_in = nsq;
               j_in  = nsq;
            end
         end
         SV_DONE: begin
         end
         default: begin
            state_in = SV_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SV_FILL;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff  <= i_in;
      sq_ff <= sq_in;
      j_ff  <= j_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prime_map_ff[wr_addr] <= wr_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_bit_ff <= prime_map_ff[rd_addr];
      end
   end

   assign rd_bit    = rd_bit_ff;
   assign map_ready = (state_ff == SV_DONE);

endmodule

// ===== sv/gpt_square_stage.sv =====
module gpt_square_stage
   import gpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  req_payload_type   in_data,
   input  logic [PART_W-1:0] m_eff,
   output logic              out_valid,
   output stage_a_type       out_data
);

   logic        vld_ff, vld_in;
   stage_a_type data_ff, data_in;
   logic        a_zero, b_zero;
   logic [PART_W-1:0] axis;

   always_comb begin
      a_zero            = (in_data.real_part == '0);
      b_zero            = (in_data.imag_part == '0);
      axis              = in_data.real_part | in_data.imag_part;
      vld_in            = in_valid;
      data_in.ok        = (in_data.real_part <= m_eff) && (in_data.imag_part <= m_eff);
      data_in.both_nz   = !a_zero && !b_zero;
      // on an axis only a prime of the form 4k+3 stays prime
      data_in.axis_cand = (a_zero ^ b_zero) && (axis[1:0] == AXIS_RESIDUE);
      data_in.axis_val  = axis;
      data_in.a_sq      = SQ_W'(in_data.real_part) * SQ_W'(in_data.real_part);
      data_in.b_sq      = SQ_W'(in_data.imag_part) * SQ_W'(in_data.imag_part);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/gaussian_prime_test.sv =====
// pipeline: registered stages square, add and map read, output
// throughput: one beat per cycle; a stalled output holds the whole pipeline
// reset: map is filled, then multiples of each i with i*i <= 2*MAX_COORD_LIMIT^2
// are struck one per cycle; req_stall stays high until then, max_coord returns to 50
// and csr writes are taken anytime
module gaussian_prime_test
   import gpt_pkg::*;
#(
   parameter int MAX_COORD_LIMIT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_payload_type   rsp_payload,
   input  logic              csr_wr_en,
   input  logic [PART_W-1:0] csr_wr_data
);

   localparam int DEPTH = 2 * MAX_COORD_LIMIT * MAX_COORD_LIMIT + 1;
   localparam int AW = $clog2(DEPTH);

   logic [PART_W-1:0] max_coord_ff;
   logic [PART_W-1:0] m_eff;
   logic              advance;
   logic              map_ready;
   logic              accept;
   logic              a_vld;
   stage_a_type       a_data;
   logic [SUM_W-1:0]  norm_sum;
   logic [AW-1:0]     rd_addr;
   logic              rd_bit;
   logic              b_vld_ff, b_vld_in;
   logic              b_ok_ff, b_ok_in;
   logic              b_want_ff, b_want_in;
   logic [SUM_W-1:0]  b_norm_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_coord_ff <= MAX_COORD_RESET;
      end else if (csr_wr_en) begin
         max_coord_ff <= csr_wr_data;
      end
   end

   assign m_eff = (int'(max_coord_ff) > MAX_COORD_LIMIT) ? PART_W'(MAX_COORD_LIMIT)
                                                          : max_coord_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance || !map_ready;
   assign accept    = req_valid && !req_stall;

   gpt_square_stage u_square (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (accept),
      .in_data   (req_payload),
      .m_eff     (m_eff),
      .out_valid (a_vld),
      .out_data  (a_data)
   );

   // off-axis queries look up the norm, axis queries the nonzero part
   always_comb begin
      norm_sum  = SUM_W'(a_data.a_sq) + SUM_W'(a_data.b_sq);
      rd_addr   = a_data.both_nz ? AW'(norm_sum) : AW'(a_data.axis_val);
      b_vld_in  = a_vld;
      b_ok_in   = a_data.ok;
      b_want_in = a_data.ok && (a_data.both_nz || a_data.axis_cand);
   end

   gpt_sieve_map #(
      .MAX_COORD_LIMIT (MAX_COORD_LIMIT)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (advance),
      .rd_addr   (rd_addr),
      .rd_bit    (rd_bit),
      .map_ready (map_ready)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (advance) begin
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ok_ff   <= b_ok_in;
         b_want_ff <= b_want_in;
         b_norm_ff <= norm_sum;
      end
   end

   always_comb begin
      rsp_payload_in.is_gaussian_prime = b_want_ff && rd_bit;
      rsp_payload_in.norm_value        = (b_norm_ff > SUM_W'(NORM_MAX)) ? NORM_MAX
                                                                        : b_norm_ff[NORM_W-1:0];
      rsp_payload_in.in_range          = b_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== sv/gpt_checker.sv =====
module gpt_checker
   import gpt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rsp_payload_type   rsp_payload
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // the map is rebuilt after reset, so no query is taken at once
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken before map rebuild");

   a_range_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.in_range |-> !rsp_payload.is_gaussian_prime)
      else $error("prime flag set out of range");

   a_prime_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_gaussian_prime |->
         rsp_payload.norm_value != 14'd0 && rsp_payload.norm_value != 14'd1)
      else $error("prime flag with norm below two");

endmodule

bind gaussian_prime_test gpt_checker u_gpt_checker (.*);
